FILE: sv/rbsi_pkg.sv
// Shared constants and register map for the ray versus box slab test.
`timescale 1ns / 1ps
package rbsi_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;

  // Register indexes on the configuration port (byte address / 4)
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  localparam int NUM_AXES = 3;

endpackage

FILE: sv/ray_box_slab_intersect.sv
// Ray versus axis-aligned box test by the slab method, one item per cycle.
// The pipe depth is set mostly by the divider pipeline, which retires one quotient
// bit per stage.
// Throughput: one item per cycle; the whole pipe holds while the output stalls.
// Reset: synchronous, clears valid bits; box returns to [0, 1.0] on each axis.
`timescale 1ns / 1ps
module ray_box_slab_intersect #(
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  localparam int PDW   = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int PAW   = (COORD_WIDTH > 32) ? 6 : 5,
  localparam int IN_W  = 6 * COORD_WIDTH,
  localparam int OUT_W = ((3 * COORD_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // hit, t_near, t_far, starts_outside, hit_distance, zero pad
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [PAW-1:0]   paddr,
  input  logic [PDW-1:0]   pwdata,
  output logic [PDW-1:0]   prdata,
  output logic             pready
);
  import rbsi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NW = CW + 1 + FRAC_BITS;
  localparam int DL = NW + 2;
  localparam int SHW = PAW - 3;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] box_lo [0:NUM_AXES-1];
  logic signed [CW-1:0] box_hi [0:NUM_AXES-1];

  // configuration port
  logic       wr;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = paddr[SHW+2:SHW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_lo[a] <= '0;
        box_hi[a] <= CW'(1) << FRAC_BITS;
      end
    end else if (wr) begin
      case (ridx)
        REG_MIN_X: box_lo[0] <= pwdata[CW-1:0];
        REG_MIN_Y: box_lo[1] <= pwdata[CW-1:0];
        REG_MIN_Z: box_lo[2] <= pwdata[CW-1:0];
        REG_MAX_X: box_hi[0] <= pwdata[CW-1:0];
        REG_MAX_Y: box_hi[1] <= pwdata[CW-1:0];
        REG_MAX_Z: box_hi[2] <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_MIN_X: prdata = PDW'(box_lo[0]);
      REG_MIN_Y: prdata = PDW'(box_lo[1]);
      REG_MIN_Z: prdata = PDW'(box_lo[2]);
      REG_MAX_X: prdata = PDW'(box_hi[0]);
      REG_MAX_Y: prdata = PDW'(box_hi[1]);
      REG_MAX_Z: prdata = PDW'(box_hi[2]);
      default:   prdata = '0;
    endcase
  end

  // pipeline control: every stage advances together
  logic en;
  logic in_v;
  logic dv_v [0:DL-1];
  logic f_v;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // input stage
  logic signed [CW-1:0] org [0:NUM_AXES-1];
  logic signed [CW-1:0] dir [0:NUM_AXES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        org[a] <= s_axis_tdata[a*CW +: CW];
        dir[a] <= s_axis_tdata[(a+NUM_AXES)*CW +: CW];
      end
    end
  end

  // side flags: per-axis zero direction and zero-direction slab miss
  logic [NUM_AXES-1:0] zd_in;
  logic                zmiss_in;
  logic [NUM_AXES-1:0] zd   [0:DL-1];
  logic                zmiss[0:DL-1];

  always_comb begin
    zmiss_in = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      zd_in[a] = (dir[a] == '0);
      if (zd_in[a] && (org[a] < box_lo[a] || org[a] > box_hi[a])) zmiss_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zd[0]    <= zd_in;
      zmiss[0] <= zmiss_in;
      for (int k = 1; k < DL; k++) begin
        zd[k]    <= zd[k-1];
        zmiss[k] <= zmiss[k-1];
      end
    end
  end

  // six dividers: entry and exit plane per axis
  logic signed [CW-1:0] t0 [0:NUM_AXES-1];
  logic signed [CW-1:0] t1 [0:NUM_AXES-1];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [CW:0] n0;
    logic signed [CW:0] n1;
    assign n0 = {box_lo[a][CW-1], box_lo[a]} - {org[a][CW-1], org[a]};
    assign n1 = {box_hi[a][CW-1], box_hi[a]} - {org[a][CW-1], org[a]};
    rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_div0 (
      .clk(clk), .en(en), .num(n0), .den(dir[a]), .q(t0[a])
    );
    rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_div1 (
      .clk(clk), .en(en), .num(n1), .den(dir[a]), .q(t1[a])
    );
  end

  // fold stage
  logic signed [CW-1:0] tn_c, tf_c, lo_c, hi_c;
  logic signed [CW-1:0] tn, tf;
  logic                 miss;

  always_comb begin
    tn_c = CMIN;
    tf_c = CMAX;
    lo_c = '0;
    hi_c = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo_c = (t0[a] < t1[a]) ? t0[a] : t1[a];
      hi_c = (t0[a] < t1[a]) ? t1[a] : t0[a];
      if (!zd[DL-1][a]) begin
        if (lo_c > tn_c) tn_c = lo_c;
        if (hi_c < tf_c) tf_c = hi_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn   <= tn_c;
      tf   <= tf_c;
      miss <= zmiss[DL-1];
    end
  end

  // output stage
  logic                 hit_c, outside_c;
  logic [OUT_W-1:0]     out_c;

  always_comb begin
    hit_c     = !miss && !(tf < 0) && !(tf < tn);
    outside_c = hit_c && (tn > 0);
    out_c     = '0;
    if (hit_c) begin
      out_c[0]            = 1'b1;
      out_c[1 +: CW]      = tn;
      out_c[1+CW +: CW]   = tf;
      out_c[1+2*CW]       = outside_c;
      out_c[2+2*CW +: CW] = outside_c ? tn : tf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= out_c;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v          <= 1'b0;
      f_v           <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < DL; k++) dv_v[k] <= 1'b0;
    end else if (en) begin
      in_v    <= s_axis_tvalid;
      dv_v[0] <= in_v;
      for (int k = 1; k < DL; k++) dv_v[k] <= dv_v[k-1];
      f_v           <= dv_v[DL-1];
      m_axis_tvalid <= f_v;
    end
  end

endmodule

FILE: sv/rbsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating result.
`timescale 1ns / 1ps
module rbsi_div #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW:0]   num,
  input  logic signed [CW-1:0] den,
  output logic signed [CW-1:0] q
);

  localparam int NW = CW + 1 + FB;
  localparam logic [NW-1:0] QMAX = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [NW-1:0] QMAG_MIN = QMAX + NW'(1);

  logic [NW-1:0] dv [0:NW];
  logic [CW-1:0] rm [0:NW];
  logic [CW-1:0] dm [0:NW];
  logic          ng [0:NW];

  logic [CW:0]   nm;
  logic [CW-1:0] dmag;

  assign nm   = num[CW] ? (~num + 1'b1) : num;
  assign dmag = den[CW-1] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= NW'(nm) << FB;
      rm[0] <= '0;
      dm[0] <= dmag;
      ng[0] <= num[CW] ^ den[CW-1];
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_step
    logic [CW:0] t;
    logic [CW:0] sub;
    logic        ge;
    assign t   = {rm[k-1], dv[k-1][NW-1]};
    assign sub = t - {1'b0, dm[k-1]};
    assign ge  = (t >= {1'b0, dm[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rm[k] <= ge ? sub[CW-1:0] : t[CW-1:0];
        dv[k] <= {dv[k-1][NW-2:0], ge};
        dm[k] <= dm[k-1];
        ng[k] <= ng[k-1];
      end
    end
  end

  // saturate into the coordinate range
  always_ff @(posedge clk) begin
    if (en) begin
      if (ng[NW]) begin
        if (dv[NW] > QMAG_MIN) q <= {1'b1, {(CW-1){1'b0}}};
        else                   q <= ~dv[NW][CW-1:0] + 1'b1;
      end else begin
        if (dv[NW] > QMAX) q <= {1'b0, {(CW-1){1'b1}}};
        else               q <= dv[NW][CW-1:0];
      end
    end
  end

endmodule

FILE: sv/rbsi_checker.sv
// Port-level checker for the slab test, bound to the top level.
`timescale 1ns / 1ps
module rbsi_checker #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int OUT_W       = ((3 * COORD_WIDTH + 2 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready
);
  import rbsi_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic                 hit, outside;
  logic signed [CW-1:0] tn, tf, hdist;
  assign hit     = m_axis_tdata[0];
  assign tn      = m_axis_tdata[1 +: CW];
  assign tf      = m_axis_tdata[1+CW +: CW];
  assign outside = m_axis_tdata[1+2*CW];
  assign hdist   = m_axis_tdata[2+2*CW +: CW];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !hit |-> tn == '0 && tf == '0 && !outside && hdist == '0)
    else $error("miss item carries nonzero fields");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && hit |-> tf >= tn && tf >= 0)
    else $error("hit with far before near");

  a_dist: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && hit |-> (outside ? hdist == tn : hdist == tf) && (outside == (tn > 0)))
    else $error("hit distance does not match near/far");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_WIDTH(COORD_WIDTH), .OUT_W(OUT_W)) u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
);

FILE: tb/ray_box_slab_checker.sv
// Checker for the ray versus box slab test: predicts each result and compares it.
`timescale 1ns / 1ps
module ray_box_slab_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending
);
  import rbsi_pkg::*;

  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_near;
    logic [31:0] t_far;
    logic        starts_outside;
    logic [31:0] hit_distance;
  } slab_result_t;

  longint box_lo[NUM_AXES];
  longint box_hi[NUM_AXES];
  slab_result_t expected_hits[$];

  assign pending = expected_hits.size();

  function automatic longint sat_quotient(longint num, longint den);
    logic neg;
    longint unsigned nm, dm, q;
    neg = (num < 0) != (den < 0);
    nm  = (num < 0) ? -num : num;
    dm  = (den < 0) ? -den : den;
    q   = (nm << 16) / dm;
    if (neg) begin
      if (q > 64'd2147483648) return SAT_MIN;
      return -longint'(q);
    end
    if (q > 64'd2147483647) return SAT_MAX;
    return longint'(q);
  endfunction

  function automatic slab_result_t trace_box(logic [191:0] ray);
    slab_result_t r;
    longint tn, tf, o, d, t0, t1, lo, hi;
    logic hit;
    tn = SAT_MIN;
    tf = SAT_MAX;
    hit = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      o = longint'($signed(ray[32*a +: 32]));
      d = longint'($signed(ray[32*(a+3) +: 32]));
      if (d != 0) begin
        t0 = sat_quotient(box_lo[a] - o, d);
        t1 = sat_quotient(box_hi[a] - o, d);
        lo = (t0 < t1) ? t0 : t1;
        hi = (t0 < t1) ? t1 : t0;
        if (lo > tn) tn = lo;
        if (hi < tf) tf = hi;
      end else if (o < box_lo[a] || o > box_hi[a]) begin
        hit = 1'b0;
      end
    end
    if (tf < 0 || tf < tn) hit = 1'b0;
    r = '0;
    if (hit) begin
      r.hit = 1'b1;
      r.t_near = tn[31:0];
      r.t_far = tf[31:0];
      r.starts_outside = tn > 0;
      r.hit_distance = (tn > 0) ? tn[31:0] : tf[31:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    slab_result_t got, want;
    if (rst) begin
      fail_count = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
        box_lo[a] = 0;
        box_hi[a] = 65536;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MIN_X, REG_MIN_Y, REG_MIN_Z: box_lo[paddr[4:2]] = longint'($signed(pwdata));
          REG_MAX_X, REG_MAX_Y, REG_MAX_Z:
            box_hi[paddr[4:2] - REG_MAX_X] = longint'($signed(pwdata));
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_hits.push_back(trace_box(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit            = m_axis_tdata[0];
        got.t_near         = m_axis_tdata[32:1];
        got.t_far          = m_axis_tdata[64:33];
        got.starts_outside = m_axis_tdata[65];
        got.hit_distance   = m_axis_tdata[97:66];
        if (expected_hits.size() == 0) begin
          report("unexpected item", 32'(got.hit), 32'h0);
        end else begin
          want = expected_hits.pop_front();
          if (got.hit != want.hit) report("hit", 32'(got.hit), 32'(want.hit));
          if (got.t_near != want.t_near) report("t_near", got.t_near, want.t_near);
          if (got.t_far != want.t_far) report("t_far", got.t_far, want.t_far);
          if (got.starts_outside != want.starts_outside)
            report("starts_outside", 32'(got.starts_outside), 32'(want.starts_outside));
          if (got.hit_distance != want.hit_distance)
            report("hit_distance", got.hit_distance, want.hit_distance);
        end
      end
    end
  end
endmodule

FILE: tb/tb_ray_box_slab_intersect.sv
// Top of the ray versus box slab testbench: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;

  localparam int LATENCY   = 53;
  localparam int WDOG_MAX  = 20000;
  localparam int RAND_RAYS = 1250;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count;
  int           pending;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles = 0;
  logic signed [31:0] box[6];

  always #4 clk = ~clk;

  ray_box_slab_intersect DUT (.*);
  ray_box_slab_checker checker_i (.*);

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_ray(logic [191:0] ray);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ray;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic finish_burst;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Write a box and keep a copy for aiming rays at it.
  task automatic set_box(logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz);
    box = '{mnx, mny, mnz, mxx, mxy, mxz};
    for (int i = 0; i < 6; i++) write_reg(3'(i), box[i]);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [191:0] rand_ray();
    logic [191:0] ray;
    for (int a = 0; a < 3; a++) begin
      // aim most origins near the box so hits are common
      ray[32*a +: 32] = $urandom_range(2) != 0
          ? 32'(box[a] + $signed(32'($urandom_range(0, 1 << 18))) - (1 << 17))
          : rand_coord();
      ray[32*(a+3) +: 32] = ($urandom_range(5) == 0) ? 32'h0 : rand_coord();
    end
    return ray;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    box = '{0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000};
    // directed: default box
    send_ray({32'h10000, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h0});
    send_ray({32'h0, 32'h0, 32'h10000, 32'h8000, 32'h8000, 32'hfffe0000});
    send_ray({32'h0, 32'h0, 32'h0, 32'h8000, 32'h8000, 32'h8000});
    send_ray({32'h0, 32'h0, 32'h0, 32'h10000, 32'h8000, 32'h8000});
    send_ray({32'h0, 32'h0, 32'h0, 32'h20000, 32'h8000, 32'h8000});
    send_ray({32'h1, 32'h0, 32'h0, 32'h7fffffff, 32'h8000, 32'h8000});
    send_ray({32'hffffffff, 32'h0, 32'h0, 32'h80000000, 32'h8000, 32'h8000});
    send_ray({32'h80000000, 32'h7fffffff, 32'h1, 32'h80000000, 32'h7fffffff, 32'h0});
    send_ray({32'h1, 32'h1, 32'h1, 32'hfff00000, 32'hfff00000, 32'hfff00000});
    send_ray({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h1});
    send_ray({32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h20000});
    send_ray({32'h10000, 32'h0, 32'h0, 32'h0, 32'h8000, 32'h8000});
    send_ray({32'h0, 32'h0, 32'h0, 32'h10001, 32'h8000, 32'h8000});
    finish_burst();
    // hold off until every result is back
    drain();
    set_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_ray({32'h1, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0});
    send_ray({32'h80000000, 32'h7fffffff, 32'h1, 32'h7fffffff, 32'h80000000, 32'h0});
    finish_burst();
    drain();
    // inverted box
    set_box(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0);
    send_ray({32'h0, 32'h0, 32'h10000, 32'h8000, 32'h8000, 32'h8000});
    send_ray({32'h8000, 32'h8000, 32'h8000, 32'h0, 32'h0, 32'h0});
    finish_burst();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (phase == 7) set_box(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000);
      else set_box(32'(rand_coord()), 32'(rand_coord()), 32'(rand_coord()),
                   32'(rand_coord()), 32'(rand_coord()), 32'(rand_coord()));
      // usually order the corners so the box is not empty
      for (int a = 0; a < 3; a++)
        if (box[a] > box[a+3] && $urandom_range(3) != 0) begin
          box[a] = box[a] ^ box[a+3];
          box[a+3] = box[a] ^ box[a+3];
          box[a] = box[a] ^ box[a+3];
          write_reg(3'(a), box[a]);
          write_reg(3'(a + 3), box[a+3]);
        end
      for (int n = 0; n < RAND_RAYS / 8; n++) begin
        send_ray(rand_ray());
        // let the sender go quiet now and then even in the no-idle phase
        if ($urandom_range(40) == 0) finish_burst();
      end
      finish_burst();
      recv_stall_pct = 0;
      drain();
    end

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: sim.f
sv/rbsi_pkg.sv
sv/rbsi_div.sv
sv/ray_box_slab_intersect.sv
sv/rbsi_checker.sv
tb/ray_box_slab_checker.sv
tb/tb_ray_box_slab_intersect.sv
